>>> rtl/csfw_pkg.sv
`timescale 1ns / 1ps

package csfw_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned IdBitsDef     = 8;
  localparam int unsigned MaxResults    = 16;
  localparam int unsigned CountW        = 16;
  localparam int unsigned TimeW         = 48;
  localparam int unsigned IdW           = 8;

  typedef enum logic [1:0] {
    OP_POST  = 2'd0,
    OP_TRY   = 2'd1,
    OP_WAIT  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_GRANTED     = 3'd0,
    ST_WOULD_BLOCK = 3'd1,
    ST_TIMED_OUT   = 3'd2,
    ST_QUEUED      = 3'd3,
    ST_WOKEN       = 3'd4,
    ST_FULL        = 3'd5,
    ST_POSTED      = 3'd6
  } status_e;

  typedef struct packed {
    op_e              operation;
    logic [IdW-1:0]   waiter_id;
    logic [TimeW-1:0] deadline;
    logic             no_deadline;
  } in_t;

  typedef struct packed {
    logic [IdW-1:0]    result_waiter;
    status_e           status;
    logic [CountW-1:0] count_now;
    logic              last;
  } out_t;

endpackage

>>> rtl/csfw_queue_ram.sv
`timescale 1ns / 1ps

module csfw_queue_ram #(
  parameter int unsigned Width = 57,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/csfw_deadline_cmp.sv
`timescale 1ns / 1ps

module csfw_deadline_cmp (
  input  logic [csfw_pkg::TimeW-1:0] now_i,
  input  logic [csfw_pkg::TimeW-1:0] deadline_i,
  input  logic                       no_deadline_i,
  output logic                       reached_o
);
  import csfw_pkg::*;

  // A deadline is reached once the current time has caught up with it.
  assign reached_o = !no_deadline_i && (now_i >= deadline_i);

endmodule

>>> rtl/counting_semaphore_fifo_waiters.sv
`timescale 1ns / 1ps

// Post, trywait and timed wait each take one word in and give one word out.
// A tick advances the time, then scans the waiter queue RAM entry by entry, a read state and
// an evaluate state per entry, then a flush state closes the burst; backpressure stalls the scan.
// One word is in flight at a time: the input is ready only while the sequencer is idle.
// Reset clears the count, the time and the queue; a configuration write reloads the count
// and empties the queue but keeps the time.
module counting_semaphore_fifo_waiters #(
  parameter int unsigned QUEUE_DEPTH = csfw_pkg::QueueDepthDef,
  parameter int unsigned ID_BITS     = csfw_pkg::IdBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  csfw_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output csfw_pkg::out_t              out_data_o,
  input  logic                        cfg_we_i,
  input  logic [csfw_pkg::CountW-1:0] cfg_data_i
);
  import csfw_pkg::*;

  localparam int unsigned IdKeep = (ID_BITS < IdW) ? ID_BITS : IdW;
  localparam int unsigned PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LenW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW   = $clog2(2 * QUEUE_DEPTH);
  localparam int unsigned NW     = $clog2(MaxResults + 1);
  localparam int unsigned EntW   = IdKeep + TimeW + 1;

  localparam logic [LenW-1:0]   LenFull  = LenW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0]   PtrLast  = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [SumW-1:0]   SumDepth = SumW'(QUEUE_DEPTH);
  localparam logic [NW-1:0]     NMax     = NW'(MaxResults);
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_POST_RD, S_POST_EMIT, S_TICK, S_SCAN_RD, S_SCAN_EV, S_FLUSH
  } state_e;

  state_e              state_q;
  logic [CountW-1:0]   sem_q;
  logic [TimeW-1:0]    time_q;
  logic [PtrW-1:0]     hd_q;
  logic [LenW-1:0]     len_q;
  logic [LenW-1:0]     idx_q;
  logic [LenW-1:0]     keep_q;
  logic [NW-1:0]       n_q;
  logic                pend_valid_q;
  logic [IdKeep-1:0]   pend_id_q;
  op_e                 op_q;
  logic [IdKeep-1:0]   id_q;
  logic [TimeW-1:0]    dl_q;
  logic                nodl_q;
  logic                out_valid_q;
  out_t                out_q;

  logic                mem_we;
  logic [PtrW-1:0]     mem_waddr;
  logic [PtrW-1:0]     mem_raddr;
  logic [EntW-1:0]     mem_wdata;
  logic [EntW-1:0]     mem_rdata;
  logic [IdKeep-1:0]   rd_id;
  logic                rd_nodl;
  logic [TimeW-1:0]    rd_dl;

  logic [TimeW-1:0]    cmp_dl;
  logic                cmp_nodl;
  logic                reached;
  logic                slot_free;
  logic                take;
  logic                wait_queues;
  logic                emit;
  logic [LenW-1:0]     idx_inc;

  function automatic logic [PtrW-1:0] wrap_ptr(input logic [SumW-1:0] sum);
    logic [SumW-1:0] r;
    r = (sum >= SumDepth) ? (sum - SumDepth) : sum;
    return r[PtrW-1:0];
  endfunction

  assign rd_id   = mem_rdata[EntW-1 -: IdKeep];
  assign rd_nodl = mem_rdata[TimeW];
  assign rd_dl   = mem_rdata[TimeW-1:0];

  // The one comparator serves the wait check and the expiry scan.
  assign cmp_dl   = (state_q == S_SCAN_EV) ? rd_dl : dl_q;
  assign cmp_nodl = (state_q == S_SCAN_EV) ? rd_nodl : nodl_q;

  csfw_deadline_cmp u_cmp (
    .now_i         (time_q),
    .deadline_i    (cmp_dl),
    .no_deadline_i (cmp_nodl),
    .reached_o     (reached)
  );

  assign slot_free   = !out_valid_q || out_ready_i;
  assign take        = reached && (n_q < NMax);
  assign idx_inc     = idx_q + LenW'(1);
  assign wait_queues = (sem_q == '0) && !reached && (len_q != LenFull);

  // High in every cycle in which the sequencer loads a new output word.
  assign emit = slot_free && ((state_q == S_EXEC) || (state_q == S_POST_EMIT) ||
                (pend_valid_q && ((state_q == S_FLUSH) || (state_q == S_SCAN_EV && take))));

  always_comb begin
    mem_raddr = (state_q == S_POST_RD || state_q == S_POST_EMIT) ? hd_q
              : wrap_ptr(SumW'(hd_q) + SumW'(idx_q));
    if (state_q == S_SCAN_EV) begin
      mem_we    = !take;
      mem_waddr = wrap_ptr(SumW'(hd_q) + SumW'(keep_q));
      mem_wdata = mem_rdata;
    end else begin
      mem_we    = (state_q == S_EXEC) && (op_q == OP_WAIT) && slot_free && wait_queues;
      mem_waddr = wrap_ptr(SumW'(hd_q) + SumW'(len_q));
      mem_wdata = {id_q, nodl_q, dl_q};
    end
  end

  csfw_queue_ram #(
    .Width (EntW),
    .Depth (QUEUE_DEPTH),
    .AddrW (PtrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sem_q        <= '0;
      time_q       <= '0;
      hd_q         <= '0;
      len_q        <= '0;
      idx_q        <= '0;
      keep_q       <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_ready_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        sem_q <= cfg_data_i;
        len_q <= '0;
        hd_q  <= '0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q   <= in_data_i.operation;
            id_q   <= in_data_i.waiter_id[IdKeep-1:0];
            dl_q   <= in_data_i.deadline;
            nodl_q <= in_data_i.no_deadline;
            if (in_data_i.operation == OP_TICK) begin
              state_q <= S_TICK;
            end else if (in_data_i.operation == OP_POST && len_q != '0) begin
              state_q <= S_POST_RD;
            end else begin
              state_q <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            out_valid_q             <= 1'b1;
            out_q.last              <= 1'b1;
            state_q                 <= S_IDLE;
            case (op_q)
              OP_POST: begin
                // The queue is empty here, so the post raises the count unless it is already at its maximum.
                out_q.result_waiter <= '0;
                out_q.status        <= ST_POSTED;
                if (sem_q != CountMax) begin
                  sem_q           <= sem_q + CountW'(1);
                  out_q.count_now <= sem_q + CountW'(1);
                end else begin
                  out_q.count_now <= sem_q;
                end
              end
              OP_TRY: begin
                out_q.result_waiter <= IdW'(id_q);
                if (sem_q != '0) begin
                  sem_q           <= sem_q - CountW'(1);
                  out_q.count_now <= sem_q - CountW'(1);
                  out_q.status    <= ST_GRANTED;
                end else begin
                  out_q.count_now <= sem_q;
                  out_q.status    <= ST_WOULD_BLOCK;
                end
              end
              default: begin
                out_q.result_waiter <= IdW'(id_q);
                if (sem_q != '0) begin
                  sem_q           <= sem_q - CountW'(1);
                  out_q.count_now <= sem_q - CountW'(1);
                  out_q.status    <= ST_GRANTED;
                end else if (reached) begin
                  out_q.count_now <= sem_q;
                  out_q.status    <= ST_TIMED_OUT;
                end else if (len_q == LenFull) begin
                  out_q.count_now <= sem_q;
                  out_q.status    <= ST_FULL;
                end else begin
                  len_q           <= len_q + LenW'(1);
                  out_q.count_now <= sem_q;
                  out_q.status    <= ST_QUEUED;
                end
              end
            endcase
          end
        end
        S_POST_RD: begin
          state_q <= S_POST_EMIT;
        end
        S_POST_EMIT: begin
          if (slot_free) begin
            out_valid_q         <= 1'b1;
            out_q.result_waiter <= IdW'(rd_id);
            out_q.status        <= ST_WOKEN;
            out_q.count_now     <= sem_q;
            out_q.last          <= 1'b1;
            hd_q                <= (hd_q == PtrLast) ? '0 : hd_q + PtrW'(1);
            len_q               <= len_q - LenW'(1);
            state_q             <= S_IDLE;
          end
        end
        S_TICK: begin
          time_q       <= time_q + TimeW'(1);
          idx_q        <= '0;
          keep_q       <= '0;
          n_q          <= '0;
          pend_valid_q <= 1'b0;
          state_q      <= (len_q == '0) ? S_IDLE : S_SCAN_RD;
        end
        S_SCAN_RD: begin
          state_q <= S_SCAN_EV;
        end
        S_SCAN_EV: begin
          // An expired waiter is held back until the next one is found or the scan ends, so that the
          // last one of the burst can carry the last marker.
          if (!take || !pend_valid_q || slot_free) begin
            if (take) begin
              if (pend_valid_q) begin
                out_valid_q         <= 1'b1;
                out_q.result_waiter <= IdW'(pend_id_q);
                out_q.status        <= ST_TIMED_OUT;
                out_q.count_now     <= sem_q;
                out_q.last          <= 1'b0;
              end
              pend_id_q    <= rd_id;
              pend_valid_q <= 1'b1;
              n_q          <= n_q + NW'(1);
            end else begin
              keep_q <= keep_q + LenW'(1);
            end
            idx_q   <= idx_inc;
            state_q <= (idx_inc == len_q) ? S_FLUSH : S_SCAN_RD;
          end
        end
        S_FLUSH: begin
          if (!pend_valid_q) begin
            len_q   <= keep_q;
            state_q <= S_IDLE;
          end else if (slot_free) begin
            out_valid_q         <= 1'b1;
            out_q.result_waiter <= IdW'(pend_id_q);
            out_q.status        <= ST_TIMED_OUT;
            out_q.count_now     <= sem_q;
            out_q.last          <= 1'b1;
            pend_valid_q        <= 1'b0;
            len_q               <= keep_q;
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> dv/csfw_checker.sv
`timescale 1ns / 1ps

module csfw_checker
  import csfw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_t               in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_t              out_data_i,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  localparam int unsigned Depth = QueueDepthDef;

  logic [CountW-1:0] sem_units;
  logic [TimeW-1:0]  now_ticks;
  logic [IdW-1:0]    waiter_ids [Depth];
  // Bit TimeW set means the waiter has no deadline.
  logic [TimeW:0]    waiter_dls [Depth];
  int unsigned       waiter_cnt;
  out_t              due_words [$];

  function automatic logic is_expired(logic [TimeW:0] dl);
    return !dl[TimeW] && (now_ticks >= dl[TimeW-1:0]);
  endfunction

  task automatic push_word(logic [IdW-1:0] who, status_e st, logic is_last);
    out_t w;
    w.result_waiter = who;
    w.status        = st;
    w.count_now     = sem_units;
    w.last          = is_last;
    due_words.push_back(w);
  endtask

  task automatic predict_word(in_t w);
    logic [IdW-1:0] head;
    int unsigned    n_due;
    int unsigned    n_out;
    int unsigned    keep;
    case (w.operation)
      OP_POST: begin
        if (waiter_cnt > 0) begin
          head = waiter_ids[0];
          for (int i = 1; i < waiter_cnt; i++) begin
            waiter_ids[i-1] = waiter_ids[i];
            waiter_dls[i-1] = waiter_dls[i];
          end
          waiter_cnt--;
          push_word(head, ST_WOKEN, 1'b1);
        end else begin
          if (sem_units != {CountW{1'b1}}) sem_units = sem_units + CountW'(1);
          push_word('0, ST_POSTED, 1'b1);
        end
      end
      OP_TRY: begin
        if (sem_units != 0) begin
          sem_units = sem_units - CountW'(1);
          push_word(w.waiter_id, ST_GRANTED, 1'b1);
        end else begin
          push_word(w.waiter_id, ST_WOULD_BLOCK, 1'b1);
        end
      end
      OP_WAIT: begin
        if (sem_units != 0) begin
          sem_units = sem_units - CountW'(1);
          push_word(w.waiter_id, ST_GRANTED, 1'b1);
        end else if (!w.no_deadline && now_ticks >= w.deadline) begin
          push_word(w.waiter_id, ST_TIMED_OUT, 1'b1);
        end else if (waiter_cnt >= Depth) begin
          push_word(w.waiter_id, ST_FULL, 1'b1);
        end else begin
          waiter_ids[waiter_cnt] = w.waiter_id;
          waiter_dls[waiter_cnt] = w.no_deadline ? {1'b1, {TimeW{1'b0}}} : {1'b0, w.deadline};
          waiter_cnt++;
          push_word(w.waiter_id, ST_QUEUED, 1'b1);
        end
      end
      OP_TICK: begin
        now_ticks = now_ticks + TimeW'(1);
        // Count the expiries first so the last one can carry the end marker.
        n_due = 0;
        for (int i = 0; i < waiter_cnt; i++) begin
          if (is_expired(waiter_dls[i]) && n_due < MaxResults) n_due++;
        end
        n_out = 0;
        keep  = 0;
        for (int i = 0; i < waiter_cnt; i++) begin
          if (is_expired(waiter_dls[i]) && n_out < MaxResults) begin
            n_out++;
            push_word(waiter_ids[i], ST_TIMED_OUT, n_out == n_due);
          end else begin
            waiter_ids[keep] = waiter_ids[i];
            waiter_dls[keep] = waiter_dls[i];
            keep++;
          end
        end
        waiter_cnt = keep;
      end
      default: ;
    endcase
  endtask

  task automatic check_word(out_t got);
    out_t want;
    if (due_words.size() == 0) begin
      $error("result word with nothing due: result_waiter %0d status %0d count_now %0d",
             got.result_waiter, got.status, got.count_now);
      fail_count_o++;
    end else begin
      want = due_words.pop_front();
      if (got.result_waiter !== want.result_waiter) begin
        $error("result_waiter: expected %0d, got %0d", want.result_waiter, got.result_waiter);
        fail_count_o++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fail_count_o++;
      end
      if (got.count_now !== want.count_now) begin
        $error("count_now: expected %0d, got %0d", want.count_now, got.count_now);
        fail_count_o++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sem_units    = '0;
      now_ticks    = '0;
      waiter_cnt   = 0;
      due_words.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // A register write reloads the count and empties the waiters but keeps the time.
      if (cfg_we_i) begin
        sem_units  = cfg_data_i;
        waiter_cnt = 0;
      end
      if (in_valid_i && in_ready_i) predict_word(in_data_i);
      if (out_valid_i && out_ready_i) check_word(out_data_i);
      pending_o = due_words.size();
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import csfw_pkg::*;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_t               in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_t              out_data_o;
  logic              cfg_we_i    = 1'b0;
  logic [CountW-1:0] cfg_data_i  = '0;
  logic              steady      = 1'b0;
  logic [TimeW-1:0]  ticks_sent  = '0;
  int unsigned       fail_count;
  int unsigned       pending;

  counting_semaphore_fifo_waiters u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  csfw_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 38);
  end

  function automatic in_t make_word(op_e op, logic [IdW-1:0] who, logic [TimeW-1:0] dl,
                                    logic nodl);
    in_t w;
    w.operation   = op;
    w.waiter_id   = who;
    w.deadline    = dl;
    w.no_deadline = nodl;
    return w;
  endfunction

  function automatic logic [TimeW-1:0] pick_deadline();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TimeMax;
      2: return r[TimeW-1:0];
      // At or just behind the current time, so a wait with a deadline and no free unit times out at once.
      3: return ticks_sent - TimeW'($urandom_range(0, 3));
      default: return ticks_sent + TimeW'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic send_word(in_t w);
    if (!steady) begin
      while ($urandom_range(0, 99) < 38) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    if (w.operation == OP_TICK) ticks_sent = ticks_sent + TimeW'(1);
  endtask

  // A tick that times nobody out gives no word, so wait out the longest scan as well.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CountW-1:0] value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Try to fill the waiter queue, at times past its depth, let time run, then wake some of the rest.
  task automatic run_fill(output int unsigned n_sent);
    int unsigned      n_wait;
    int unsigned      n_tick;
    int unsigned      n_post;
    logic             same_dl;
    logic [TimeW-1:0] dl;
    n_wait  = $urandom_range(14, 18);
    n_tick  = $urandom_range(2, 8);
    n_post  = $urandom_range(0, 4);
    same_dl = 1'($urandom_range(0, 1));
    dl      = ticks_sent + TimeW'(1);
    for (int i = 0; i < n_wait; i++) begin
      if (!same_dl) dl = ticks_sent + TimeW'($urandom_range(1, 6));
      send_word(make_word(OP_WAIT, 8'($urandom), dl, !same_dl && $urandom_range(0, 4) == 0));
    end
    repeat (n_tick) send_word(make_word(OP_TICK, 8'($urandom), pick_deadline(), 1'($urandom)));
    repeat (n_post) send_word(make_word(OP_POST, 8'($urandom), pick_deadline(), 1'($urandom)));
    n_sent = n_wait + n_tick + n_post;
  endtask

  task automatic run_random(int unsigned n_words);
    int unsigned sent;
    int unsigned k;
    sent = 0;
    while (sent < n_words) begin
      if (sent == 0 || $urandom_range(0, 5) == 0) begin
        run_fill(k);
        sent += k;
      end else begin
        send_word(make_word(op_e'($urandom_range(0, 3)), 8'($urandom), pick_deadline(),
                            1'($urandom_range(0, 1))));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_count('0);
    send_word(make_word(OP_TRY,  8'h00, '0,      1'b0));
    send_word(make_word(OP_TRY,  8'hFF, TimeMax, 1'b1));
    send_word(make_word(OP_WAIT, 8'h01, '0,      1'b0));
    send_word(make_word(OP_WAIT, 8'h80, TimeMax, 1'b1));
    send_word(make_word(OP_WAIT, 8'h55, 48'd2,   1'b0));
    send_word(make_word(OP_WAIT, 8'hAA, TimeMax, 1'b0));
    send_word(make_word(OP_TICK, 8'h00, '0,      1'b0));
    send_word(make_word(OP_TICK, 8'hFF, TimeMax, 1'b1));
    send_word(make_word(OP_POST, 8'h00, '0,      1'b0));
    send_word(make_word(OP_POST, 8'hFF, TimeMax, 1'b1));
    send_word(make_word(OP_POST, 8'h00, '0,      1'b0));
    // A unit is available, so the wait is granted even though its deadline has passed.
    send_word(make_word(OP_WAIT, 8'h33, '0,      1'b0));
    send_word(make_word(OP_TRY,  8'h34, '0,      1'b0));

    // The count saturates at its maximum.
    write_count({CountW{1'b1}});
    send_word(make_word(OP_POST, 8'h00, '0,      1'b0));
    send_word(make_word(OP_WAIT, 8'h12, TimeMax, 1'b0));
    send_word(make_word(OP_POST, 8'h00, '0,      1'b0));
    send_word(make_word(OP_POST, 8'h00, '0,      1'b0));
    send_word(make_word(OP_TRY,  8'h21, '0,      1'b0));
    run_random(60);

    write_count('0);
    steady <= 1'b1;
    run_random(110);
    steady <= 1'b0;

    write_count(16'd3);
    run_random(80);

    write_count(CountW'($urandom_range(1, 12)));
    run_random(80);

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
